[rtl/core/msdf_defect_correction_macros.svh]
// Assertion macros shared by the defect correction RTL.
// MDC_ASSERT checks a property at every rising clock edge outside reset.
// MDC_ASSERT_NEXT checks that a condition is followed by another in the next cycle.
`ifndef MSDF_DEFECT_CORRECTION_MACROS_SVH
`define MSDF_DEFECT_CORRECTION_MACROS_SVH
`ifndef SYNTH
`define MDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define MDC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: assertion failed");
`else
`define MDC_ASSERT(label, clk, rst, prop)
`define MDC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[rtl/core/mdc_pkg.sv]
`default_nettype none

package mdc_pkg;

   localparam int PIX_W       = 24;
   localparam int CH_W        = 8;
   localparam int IMG_W_W     = 9;
   localparam int IMG_H_W     = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 9'd256;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd256;

   // One classified pixel on its way from the front to the back.
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [CH_W-1:0]  med;
      logic [2:0]       up_sign;
      logic             first_col;
      logic             last_col;
      logic             last_row;
      logic             row_nz;
   } mdc_entry_type;

endpackage

`default_nettype wire

[rtl/core/msdf_defect_correction.sv]
// Streaming defect corrector for multi-channel signed distance field pixels.
// Input queue side: present req_pixel_in with req_push; the item is taken on a
// clock edge where req_full is low. Pixels arrive row by row, image_width per
// row and image_height rows per frame, set through csr_write_en, csr_index and
// csr_wdata while the block is idle.
// Result queue side: while rsp_empty is low the oldest result sits on the rsp_
// ports; rsp_pop takes it. A pixel is released when its right neighbor arrives,
// so the last pixel of a row yields two results: its held left neighbor, then
// itself (rsp_last_of_input marks the final result of each input).
// A releasing input passes the front register and the queue; its result is then
// registered. Throughput is one pixel per cycle while rsp_pop keeps up; at a row
// end the single result register drains the two results in turn.
// A four-entry queue between classification and correction, plus a one-stage
// front register, absorb a stalled receiver; req_full rises once both are full.
// Reset empties all queues, zeroes column and row position and sets both sizes
// to 256. The earlier-row store is not cleared: the first row never uses it.
`default_nettype none

module msdf_defect_correction #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [mdc_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [mdc_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic                                rsp_was_corrected,
   output logic                                rsp_last_of_input,
   output logic                                rsp_end_of_frame,
   input  wire logic                           csr_write_en,
   input  wire logic [mdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mdc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mdc_pkg::*;

   mdc_entry_type entry, head;
   logic          entry_valid, q_full, q_empty, q_pop;

   mdc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .pixel        (req_pixel_in),
      .full         (req_full),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .entry_valid  (entry_valid),
      .entry        (entry),
      .q_full       (q_full)
   );

   mdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (entry_valid),
      .push_data (entry),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   mdc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_was_corrected (rsp_was_corrected),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_frame  (rsp_end_of_frame)
   );

endmodule

`default_nettype wire

[rtl/core/mdc_front.sv]
`default_nettype none

module mdc_front #(
   parameter int MAX_WIDTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [mdc_pkg::PIX_W-1:0]     pixel,
   output logic                               full,
   input  wire logic                          csr_write_en,
   input  wire logic [mdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mdc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                               entry_valid,
   output mdc_pkg::mdc_entry_type             entry,
   input  wire logic                          q_full
);
   import mdc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;

   logic [IMG_W_W-1:0] img_width_ff, img_width_in;
   logic [IMG_H_W-1:0] img_height_ff, img_height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [IMG_H_W-1:0] row_ff, row_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic [CH_W-1:0]    s1_med_ff;
   logic               s1_first_col_ff, s1_last_col_ff, s1_last_row_ff, s1_row_nz_ff;

   logic [PIX_W-1:0]   row_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   row_rd_ff;

   logic               s1_adv, accept, last_col, last_row;
   logic [CMP_W-1:0]   width_eff, width_ext, col_next_ext;
   logic [IMG_H_W:0]   height_eff, row_next_ext;

   function automatic logic [CH_W-1:0] median3(input logic [PIX_W-1:0] v);
      logic [CH_W-1:0] a, b, c, lo, hi, mid;
      a = v[CH_W-1:0];
      b = v[2*CH_W-1:CH_W];
      c = v[3*CH_W-1:2*CH_W];
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      mid = (hi < c) ? hi : c;
      return (lo > mid) ? lo : mid;
   endfunction

   assign s1_adv = !s1_valid_ff || !q_full;
   assign full   = !s1_adv;
   assign accept = push && s1_adv;

   // Clamp the programmed sizes to the usable range.
   always_comb begin
      width_ext = CMP_W'(img_width_ff);
      if (img_width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      height_eff   = (img_height_ff == '0) ? (IMG_H_W+1)'(1) : {1'b0, img_height_ff};
      col_next_ext = CMP_W'(col_ff) + CMP_W'(1);
      row_next_ext = {1'b0, row_ff} + (IMG_H_W+1)'(1);
      last_col     = col_next_ext >= width_eff;
      last_row     = row_next_ext >= height_eff;
   end

   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  img_width_in  = csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: img_height_in = csr_wdata;
            default: ;
         endcase
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next_ext[IMG_H_W-1:0];
         end else begin
            col_in = col_next_ext[COL_W-1:0];
         end
      end
      s1_valid_in = s1_adv ? push : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= IMAGE_WIDTH_RESET;
         img_height_ff <= IMAGE_HEIGHT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= pixel;
         s1_med_ff       <= median3(pixel);
         s1_first_col_ff <= (col_ff == '0);
         s1_last_col_ff  <= last_col;
         s1_last_row_ff  <= last_row;
         s1_row_nz_ff    <= (row_ff != '0);
      end
   end

   // Read the earlier row's pixel in this column, then overwrite it with this one.
   always_ff @(posedge clock) begin
      if (accept) begin
         row_rd_ff       <= row_mem[col_ff];
         row_mem[col_ff] <= pixel;
      end
   end

   assign entry_valid     = s1_valid_ff;
   assign entry.pix       = s1_pix_ff;
   assign entry.med       = s1_med_ff;
   assign entry.up_sign   = {row_rd_ff[3*CH_W-1], row_rd_ff[2*CH_W-1], row_rd_ff[CH_W-1]};
   assign entry.first_col = s1_first_col_ff;
   assign entry.last_col  = s1_last_col_ff;
   assign entry.last_row  = s1_last_row_ff;
   assign entry.row_nz    = s1_row_nz_ff;

endmodule

`default_nettype wire

[rtl/core/mdc_queue.sv]
`default_nettype none

`include "msdf_defect_correction_macros.svh"

module mdc_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  mdc_pkg::mdc_entry_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output mdc_pkg::mdc_entry_type head,
   output logic                   empty
);
   import mdc_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   mdc_entry_type slots_ff [QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MDC_ASSERT(a_q_no_overflow, clock, reset, count_ff <= (AW+1)'(QUEUE_DEPTH))
   `MDC_ASSERT(a_q_no_underflow, clock, reset, !(pop && empty))
   `MDC_ASSERT_NEXT(a_q_push_fills, clock, reset, push && !full && !pop, !empty)
   `MDC_ASSERT(a_q_ptr_gap, clock, reset, AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[AW-1:0])

endmodule

`default_nettype wire

[rtl/core/mdc_back.sv]
`default_nettype none

`include "msdf_defect_correction_macros.svh"

module mdc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   input  mdc_pkg::mdc_entry_type         q_head,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [mdc_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic                           rsp_was_corrected,
   output logic                           rsp_last_of_input,
   output logic                           rsp_end_of_frame
);
   import mdc_pkg::*;

   logic             phase_ff, phase_in;
   logic [PIX_W-1:0] held_pix_ff, held_pix_in;
   logic [CH_W-1:0]  held_med_ff, held_med_in;
   logic [2:0]       held_up_ff, held_up_in;

   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] out_pix_ff, out_pix_in;
   logic             out_corr_ff, out_corr_in;
   logic             out_last_ff, out_last_in;
   logic             out_eof_ff, out_eof_in;

   logic             out_adv, fix;
   logic [2:0]       held_sign, head_sign;

   function automatic logic is_defect(input logic [2:0] a, input logic [2:0] b);
      logic mixed_a, mixed_b, maj_a, maj_b;
      mixed_a = (a != 3'b000) && (a != 3'b111);
      mixed_b = (b != 3'b000) && (b != 3'b111);
      // Median above mid-scale exactly when most sign bits are set.
      maj_a = (a[0] & a[1]) | (a[0] & a[2]) | (a[1] & a[2]);
      maj_b = (b[0] & b[1]) | (b[0] & b[2]) | (b[1] & b[2]);
      return mixed_a && mixed_b && (a != b) && (maj_a == maj_b);
   endfunction

   assign out_adv   = !out_valid_ff || rsp_pop;
   assign held_sign = {held_pix_ff[3*CH_W-1], held_pix_ff[2*CH_W-1], held_pix_ff[CH_W-1]};
   assign head_sign = {q_head.pix[3*CH_W-1], q_head.pix[2*CH_W-1], q_head.pix[CH_W-1]};
   assign fix       = q_head.row_nz &&
                      (is_defect(held_sign, head_sign) || is_defect(held_sign, held_up_ff));

   always_comb begin
      q_pop        = 1'b0;
      phase_in     = phase_ff;
      held_pix_in  = held_pix_ff;
      held_med_in  = held_med_ff;
      held_up_in   = held_up_ff;
      out_valid_in = out_adv ? 1'b0 : out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_corr_in  = out_corr_ff;
      out_last_in  = out_last_ff;
      out_eof_in   = out_eof_ff;
      if (!q_empty && out_adv) begin
         if (phase_ff || (q_head.first_col && q_head.last_col)) begin
            // Release the row's last pixel unchanged.
            q_pop        = 1'b1;
            phase_in     = 1'b0;
            out_valid_in = 1'b1;
            out_pix_in   = q_head.pix;
            out_corr_in  = 1'b0;
            out_last_in  = 1'b1;
            out_eof_in   = q_head.last_row;
         end else if (q_head.first_col) begin
            // Hold the first pixel of a row until its neighbor shows up.
            q_pop       = 1'b1;
            held_pix_in = q_head.pix;
            held_med_in = q_head.med;
            held_up_in  = q_head.up_sign;
         end else begin
            out_valid_in = 1'b1;
            out_pix_in   = fix ? {3{held_med_ff}} : held_pix_ff;
            out_corr_in  = fix;
            out_last_in  = !q_head.last_col;
            out_eof_in   = 1'b0;
            if (q_head.last_col) begin
               phase_in = 1'b1;
            end else begin
               q_pop       = 1'b1;
               held_pix_in = q_head.pix;
               held_med_in = q_head.med;
               held_up_in  = q_head.up_sign;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_pix_ff <= held_pix_in;
      held_med_ff <= held_med_in;
      held_up_ff  <= held_up_in;
      out_pix_ff  <= out_pix_in;
      out_corr_ff <= out_corr_in;
      out_last_ff <= out_last_in;
      out_eof_ff  <= out_eof_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_pixel_out     = out_pix_ff;
   assign rsp_was_corrected = out_corr_ff;
   assign rsp_last_of_input = out_last_ff;
   assign rsp_end_of_frame  = out_eof_ff;

   `MDC_ASSERT(a_back_phase_has_head, clock, reset, !phase_ff || !q_empty)
   `MDC_ASSERT(a_back_corr_gray, clock, reset, !(out_valid_ff && out_corr_ff) || ((out_pix_ff[7:0] == out_pix_ff[15:8]) && (out_pix_ff[15:8] == out_pix_ff[23:16])))
   `MDC_ASSERT(a_back_eof_last, clock, reset, !(out_valid_ff && out_eof_ff) || (out_last_ff && !out_corr_ff))
   `MDC_ASSERT_NEXT(a_back_phase_next, clock, reset, phase_ff && !q_empty && out_adv, !phase_ff)

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   import mdc_pkg::*;

   localparam int STORE_DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             corrected;
      logic             last_in;
      logic             frame_end;
   } pixel_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_was_corrected;
   logic                  rsp_last_of_input;
   logic                  rsp_end_of_frame;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // stream state mirrored from the block
   logic [PIX_W-1:0]   row_store [STORE_DEPTH];
   bit                 row_store_valid [STORE_DEPTH];
   logic [PIX_W-1:0]   held_px = '0;
   int                 col_idx = 0;
   logic [IMG_H_W-1:0] row_idx = '0;
   logic [IMG_W_W-1:0] width_reg = IMAGE_WIDTH_RESET;
   logic [IMG_H_W-1:0] height_reg = IMAGE_HEIGHT_RESET;

   logic [PIX_W-1:0] pixels_to_send [$];
   pixel_result_t    pending_results [$];
   int               errors = 0;
   int               send_idle_pct = 0;
   int               rcv_stall_pct = 0;
   bit               hold_go = 1'b0;
   int               hold_left = 0;
   int               quiet_cycles = 0;

   msdf_defect_correction dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pixel_in      (req_pixel_in),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_was_corrected (rsp_was_corrected),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_end_of_frame  (rsp_end_of_frame),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [CH_W-1:0] median3(input logic [PIX_W-1:0] p);
      logic [CH_W-1:0] a, b, c, t;
      a = p[7:0];
      b = p[15:8];
      c = p[23:16];
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
      return b;
   endfunction

   // Mixed sign patterns that differ, with medians on the same side of mid-scale.
   function automatic bit sign_conflict(input logic [PIX_W-1:0] p, input logic [PIX_W-1:0] q);
      logic [2:0] sp, sq;
      sp = {p[23], p[15], p[7]};
      sq = {q[23], q[15], q[7]};
      if (sp == 3'b000 || sq == 3'b000 || sp == 3'b111 || sq == 3'b111 || sp == sq)
         return 1'b0;
      return (median3(p) > 8'd127) == (median3(q) > 8'd127);
   endfunction

   function automatic int eff_width(input logic [IMG_W_W-1:0] w);
      if (w == 0) return 1;
      if (w > STORE_DEPTH) return STORE_DEPTH;
      return int'(w);
   endfunction

   task automatic correct_pixel(input logic [PIX_W-1:0] p);
      int w, h;
      bit last_col, last_row, fix;
      logic [PIX_W-1:0] up;
      logic [CH_W-1:0] m;
      w = eff_width(width_reg);
      h = (height_reg == 0) ? 1 : int'(height_reg);
      last_col = (col_idx + 1 >= w);
      last_row = (int'(row_idx) + 1 >= h);
      if (col_idx > 0) begin
         up = row_store[col_idx-1];
         fix = (row_idx != 0) && (sign_conflict(held_px, p) || sign_conflict(held_px, up));
         row_store[col_idx-1] = held_px;
         row_store_valid[col_idx-1] = 1'b1;
         if (fix) begin
            m = median3(held_px);
            pending_results.push_back('{{m, m, m}, 1'b1, !last_col, 1'b0});
         end else begin
            pending_results.push_back('{held_px, 1'b0, !last_col, 1'b0});
         end
      end
      if (last_col) begin
         row_store[col_idx] = p;
         row_store_valid[col_idx] = 1'b1;
         pending_results.push_back('{p, 1'b0, 1'b1, last_row});
         col_idx = 0;
         row_idx = last_row ? '0 : row_idx + 1'b1;
      end else begin
         held_px = p;
         col_idx = col_idx + 1;
      end
   endtask

   // A new width must not make a later row read a store entry never written.
   function automatic bit width_is_safe(input int w);
      int lo, hi;
      if (row_idx == 0) return 1'b1;
      lo = (col_idx == 0) ? 0 : col_idx - 1;
      hi = w - 2;
      if (col_idx > 0 && hi < col_idx - 1) hi = col_idx - 1;
      for (int i = lo; i <= hi; i++)
         if (!row_store_valid[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [PIX_W-1:0] p;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(3))
            0: p[ch*8 +: 8] = 8'h80 + 8'($urandom_range(3));
            1: p[ch*8 +: 8] = 8'h7f - 8'($urandom_range(3));
            default: p[ch*8 +: 8] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg = data[IMG_W_W-1:0];
      else height_reg = data[IMG_H_W-1:0];
   endtask

   // Wait until every item is taken and every result is back, then let the pipe settle.
   task automatic wait_drained();
      @(negedge clock);
      while (pixels_to_send.size() != 0 || req_push || pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) pixels_to_send.push_back(random_pixel());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_push <= 1'b1;
            req_pixel_in <= pixels_to_send.pop_front();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      pixel_result_t got, want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_pixel_out, rsp_was_corrected, rsp_last_of_input, rsp_end_of_frame};
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: pixel %06h corrected %0b last %0b eof %0b",
                           got.pixel, got.corrected, got.last_in, got.frame_end);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: expected pixel %06h corrected %0b last %0b eof %0b,",
                               " got pixel %06h corrected %0b last %0b eof %0b"},
                              want.pixel, want.corrected, want.last_in, want.frame_end,
                              got.pixel, got.corrected, got.last_in, got.frame_end);
               end
            end
         end
         if (req_push && !req_full) correct_pixel(req_pixel_in);
         rsp_pop <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_go) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("msdf_defect_correction test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [PIX_W-1:0] corner_px [12];
      logic [IMG_W_W-1:0] w_try;
      logic [IMG_H_W-1:0] h_try;
      logic [6:0] w_high;
      int tries;
      corner_px = '{24'h000000, 24'hffffff, 24'h808080, 24'h7f7f7f,
                    24'h808000, 24'h008080, 24'h800080, 24'hff7f00,
                    24'h7f0080, 24'h00807f, 24'h80017f, 24'h7f8080};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // three rows of four: extremes, then rows with sign conflicts
      write_csr(CSR_IMAGE_WIDTH, 16'd4);
      write_csr(CSR_IMAGE_HEIGHT, 16'd3);
      foreach (corner_px[i]) pixels_to_send.push_back(corner_px[i]);
      wait_drained();

      // stop inside the second row, then narrow the image so the next item ends row and frame
      write_csr(CSR_IMAGE_WIDTH, 16'd5);
      write_csr(CSR_IMAGE_HEIGHT, 16'd7);
      send_random(7);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, 16'd3);
      write_csr(CSR_IMAGE_HEIGHT, 16'd1);
      send_random(3);
      wait_drained();

      // single-pixel rows, entered with the column already past the end
      write_csr(CSR_IMAGE_WIDTH, 16'd1);
      write_csr(CSR_IMAGE_HEIGHT, 16'd2);
      send_random(2);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, 16'd0);
      write_csr(CSR_IMAGE_HEIGHT, 16'd0);
      send_random(1);
      wait_drained();

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 74; end
            default: begin send_idle_pct = 10; rcv_stall_pct = 10; end
         endcase
         w_try = width_reg;
         for (tries = 0; tries < 8; tries++) begin
            case ($urandom_range(9))
               0: w_try = 9'd0;
               1: w_try = 9'd1;
               2: w_try = 9'd256;
               3: w_try = 9'd511;
               4: w_try = 9'($urandom_range(257, 511));
               default: w_try = 9'($urandom_range(2, 12));
            endcase
            if (width_is_safe(eff_width(w_try))) break;
         end
         if (tries == 8) w_try = width_reg;
         w_high = ($urandom_range(3) == 0) ? 7'($urandom) : 7'd0;
         write_csr(CSR_IMAGE_WIDTH, {w_high, w_try});
         case ($urandom_range(5))
            0: h_try = 16'd0;
            1: h_try = 16'hffff;
            default: h_try = 16'($urandom_range(1, 4));
         endcase
         write_csr(CSR_IMAGE_HEIGHT, h_try);
         if (phase == 5) begin
            // hold the result side off while items keep coming so the input backs up
            send_idle_pct = 0;
            rcv_stall_pct = 0;
            @(negedge clock);
            hold_go = 1'b1;
            @(negedge clock);
            hold_go = 1'b0;
         end
         send_random(50);
         wait_drained();
      end

      if (errors == 0 && pending_results.size() == 0) begin
         $display("msdf_defect_correction test passed");
      end else begin
         $display("msdf_defect_correction test failed");
      end
      $finish;
   end

endmodule
